@@ hw/rtl/tbic_pkg.sv @@
// Shared definitions for the two-bank interrupt controller: function codes,
// register offsets, item types and the lowest-set-bit encoder.
// No dependencies.
`default_nettype none

package tbic_pkg;

    localparam int unsigned WordWidth = 32;
    localparam int unsigned LineIdxWidth = 6;
    localparam int unsigned BitIdxWidth = 5;

    // Function codes of an input transaction
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    // Register map, byte offsets
    localparam logic [4:0] OFS_HIGH_EVENTS  = 5'h00;
    localparam logic [4:0] OFS_HIGH_ENABLES = 5'h04;
    localparam logic [4:0] OFS_HIGH_CLEAR   = 5'h08;
    localparam logic [4:0] OFS_LOW_EVENTS   = 5'h10;
    localparam logic [4:0] OFS_LOW_ENABLES  = 5'h14;
    localparam logic [4:0] OFS_LOW_CLEAR    = 5'h18;

    typedef struct packed {
        logic [1:0]           func;
        logic [4:0]           reg_offset;
        logic [WordWidth-1:0] write_data;
        logic [WordWidth-1:0] lines_low;
        logic [WordWidth-1:0] lines_high;
    } req_item_t;

    typedef struct packed {
        logic [WordWidth-1:0]    read_data;
        logic                    irq_request;
        logic [LineIdxWidth-1:0] first_pending;
        logic                    pending_valid;
    } rsp_item_t;

    // Priority encoder: index of the lowest set bit, 0 when none is set
    function automatic logic [BitIdxWidth-1:0] lowest_bit(input logic [WordWidth-1:0] v);
        logic [BitIdxWidth-1:0] idx;
        idx = '0;
        for (int i = WordWidth - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = BitIdxWidth'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tbic_if.sv @@
// Valid/ready channel interfaces for the two-bank interrupt controller.
// Depends on tbic_pkg for widths.
`default_nettype none

interface tbic_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     func;
    logic [4:0]                     reg_offset;
    logic [tbic_pkg::WordWidth-1:0] write_data;
    logic [tbic_pkg::WordWidth-1:0] lines_low;
    logic [tbic_pkg::WordWidth-1:0] lines_high;

    modport source (output valid, func, reg_offset, write_data, lines_low, lines_high,
                    input ready);
    modport sink   (input valid, func, reg_offset, write_data, lines_low, lines_high,
                    output ready);
endinterface

interface tbic_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [tbic_pkg::WordWidth-1:0]    read_data;
    logic                              irq_request;
    logic [tbic_pkg::LineIdxWidth-1:0] first_pending;
    logic                              pending_valid;

    modport source (output valid, read_data, irq_request, first_pending, pending_valid,
                    input ready);
    modport sink   (input valid, read_data, irq_request, first_pending, pending_valid,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/two_bank_interrupt_controller_core.sv @@
// Two-bank, 64-line interrupt controller core.
// Depends on tbic_pkg and the channel interfaces in tbic_if.sv.
//
// Usage:
//   req carries one transaction per handshake: a tick that ORs lines_low and
//   lines_high into the event registers, a bus read, or a bus write that loads
//   an enable register or clears event bits (write one to clear).
//   rsp returns exactly one transaction per request, in order: read_data for a
//   read (else 0), plus irq_request and the lowest enabled pending line taken
//   from the state after that request has been applied.
// Pipeline: an accepted request is held and applied in the input register,
//   then the masking and 32-bit priority encode feed the response register.
// Throughput: one transaction per cycle while rsp is not stalled, set by the
//   single response register and the encoder between it and the input
//   register.
// Reset: all events cleared, all lines masked, both pipeline stages empty.
// Stall: while rsp.ready is low the response holds; the input register still
//   takes one more request, after which req.ready drops until rsp drains.
`default_nettype none

module two_bank_interrupt_controller_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tbic_req_if.sink     req,
    tbic_rsp_if.source   rsp
);

    localparam int unsigned W = tbic_pkg::WordWidth;

    tbic_pkg::req_item_t in_item_reg;
    logic                in_valid_reg;
    tbic_pkg::rsp_item_t out_item_reg;
    tbic_pkg::rsp_item_t out_item_next;
    logic                out_valid_reg;

    logic [W-1:0] low_events_reg,   low_events_next;
    logic [W-1:0] high_events_reg,  high_events_next;
    logic [W-1:0] low_enables_reg,  low_enables_next;
    logic [W-1:0] high_enables_reg, high_enables_next;

    logic [W-1:0] low_pend;
    logic [W-1:0] high_pend;
    logic [W-1:0] rdata;
    logic         advance;
    logic         accept;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    // Apply the held transaction to the bank registers
    always_comb
    begin
        low_events_next   = low_events_reg;
        high_events_next  = high_events_reg;
        low_enables_next  = low_enables_reg;
        high_enables_next = high_enables_reg;
        rdata             = '0;
        case (in_item_reg.func)
            tbic_pkg::FUNC_TICK:
            begin
                low_events_next  = low_events_reg | in_item_reg.lines_low;
                high_events_next = high_events_reg | in_item_reg.lines_high;
            end
            tbic_pkg::FUNC_READ:
            begin
                case (in_item_reg.reg_offset)
                    tbic_pkg::OFS_HIGH_EVENTS:  rdata = high_events_reg;
                    tbic_pkg::OFS_HIGH_ENABLES: rdata = high_enables_reg;
                    tbic_pkg::OFS_LOW_EVENTS:   rdata = low_events_reg;
                    tbic_pkg::OFS_LOW_ENABLES:  rdata = low_enables_reg;
                    default:                    rdata = '0;
                endcase
            end
            tbic_pkg::FUNC_WRITE:
            begin
                case (in_item_reg.reg_offset)
                    tbic_pkg::OFS_HIGH_ENABLES: high_enables_next = in_item_reg.write_data;
                    tbic_pkg::OFS_LOW_ENABLES:  low_enables_next = in_item_reg.write_data;
                    tbic_pkg::OFS_HIGH_CLEAR:
                        high_events_next = high_events_reg & ~in_item_reg.write_data;
                    tbic_pkg::OFS_LOW_CLEAR:
                        low_events_next = low_events_reg & ~in_item_reg.write_data;
                    default: ;
                endcase
            end
            default: ;
        endcase

        low_pend  = low_events_next & low_enables_next;
        high_pend = high_events_next & high_enables_next;

        out_item_next.read_data = rdata;
        if (low_pend != '0)
        begin
            out_item_next.irq_request   = 1'b1;
            out_item_next.pending_valid = 1'b1;
            out_item_next.first_pending = {1'b0, tbic_pkg::lowest_bit(low_pend)};
        end
        else if (high_pend != '0)
        begin
            out_item_next.irq_request   = 1'b1;
            out_item_next.pending_valid = 1'b1;
            out_item_next.first_pending = {1'b1, tbic_pkg::lowest_bit(high_pend)};
        end
        else
        begin
            out_item_next.irq_request   = 1'b0;
            out_item_next.pending_valid = 1'b0;
            out_item_next.first_pending = '0;
        end
    end

    // Control and bank state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            low_events_reg   <= '0;
            high_events_reg  <= '0;
            low_enables_reg  <= '0;
            high_enables_reg <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                low_events_reg   <= low_events_next;
                high_events_reg  <= high_events_next;
                low_enables_reg  <= low_enables_next;
                high_enables_reg <= high_enables_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.func       <= req.func;
            in_item_reg.reg_offset <= req.reg_offset;
            in_item_reg.write_data <= req.write_data;
            in_item_reg.lines_low  <= req.lines_low;
            in_item_reg.lines_high <= req.lines_high;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_data     = out_item_reg.read_data;
    assign rsp.irq_request   = out_item_reg.irq_request;
    assign rsp.first_pending = out_item_reg.first_pending;
    assign rsp.pending_valid = out_item_reg.pending_valid;

endmodule

`default_nettype wire

@@ test/tbic_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the two-bank interrupt controller core: watches both channels,
// predicts every response from its own copy of the event and enable registers
// and compares field by field. Depends on tbic_pkg and the interfaces in tbic_if.sv.

module tbic_checker (
    input  logic clk,
    input  logic rst_n,
    tbic_req_if  req,
    tbic_rsp_if  rsp,
    output int   mismatches,
    output int   responses_seen,
    output int   outstanding
);
    import tbic_pkg::*;

    logic [WordWidth-1:0] low_events;
    logic [WordWidth-1:0] high_events;
    logic [WordWidth-1:0] low_enables;
    logic [WordWidth-1:0] high_enables;
    rsp_item_t            expected_rsp_q[$];

    function automatic logic [BitIdxWidth-1:0] first_set_bit(input logic [WordWidth-1:0] word);
        logic [BitIdxWidth-1:0] pos;
        logic                   found;
        pos = '0;
        found = 1'b0;
        for (int i = 0; i < WordWidth; i++)
        begin
            if (word[i] && !found)
            begin
                pos = BitIdxWidth'(i);
                found = 1'b1;
            end
        end
        return pos;
    endfunction

    // Apply one request to the register copy and return the response it yields
    function automatic rsp_item_t apply_request(input req_item_t item);
        rsp_item_t            result;
        logic [WordWidth-1:0] low_pend;
        logic [WordWidth-1:0] high_pend;
        result = '0;
        case (item.func)
            FUNC_TICK:
            begin
                low_events  = low_events | item.lines_low;
                high_events = high_events | item.lines_high;
            end
            FUNC_READ:
            begin
                case (item.reg_offset)
                    OFS_HIGH_EVENTS:  result.read_data = high_events;
                    OFS_HIGH_ENABLES: result.read_data = high_enables;
                    OFS_LOW_EVENTS:   result.read_data = low_events;
                    OFS_LOW_ENABLES:  result.read_data = low_enables;
                    default:          result.read_data = '0;
                endcase
            end
            FUNC_WRITE:
            begin
                case (item.reg_offset)
                    OFS_HIGH_ENABLES: high_enables = item.write_data;
                    OFS_LOW_ENABLES:  low_enables = item.write_data;
                    OFS_HIGH_CLEAR:   high_events = high_events & ~item.write_data;
                    OFS_LOW_CLEAR:    low_events = low_events & ~item.write_data;
                    default:          ;
                endcase
            end
            default: ;
        endcase

        // Low bank wins over high bank
        low_pend  = low_events & low_enables;
        high_pend = high_events & high_enables;
        if (low_pend != '0)
        begin
            result.first_pending = {1'b0, first_set_bit(low_pend)};
            result.pending_valid = 1'b1;
        end
        else if (high_pend != '0)
        begin
            result.first_pending = {1'b1, first_set_bit(high_pend)};
            result.pending_valid = 1'b1;
        end
        result.irq_request = result.pending_valid;
        return result;
    endfunction

    task automatic compare_field(input string label, input logic [WordWidth-1:0] want,
                                 input logic [WordWidth-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_item_t want;
        req_item_t seen;
        if (!rst_n)
        begin
            low_events = '0;
            high_events = '0;
            low_enables = '0;
            high_enables = '0;
            expected_rsp_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // Retire the response first: it can never belong to a request taken at this edge
            if ((rsp.valid && rsp.ready) === 1'b1)
            begin
                responses_seen++;
                if (expected_rsp_q.size() == 0)
                begin
                    $display("%0t: response with nothing outstanding, read_data %0h",
                             $time, rsp.read_data);
                    mismatches++;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    compare_field("read_data", want.read_data, rsp.read_data);
                    compare_field("irq_request", want.irq_request, rsp.irq_request);
                    compare_field("first_pending", want.first_pending, rsp.first_pending);
                    compare_field("pending_valid", want.pending_valid, rsp.pending_valid);
                end
            end
            if ((req.valid && req.ready) === 1'b1)
            begin
                seen.func = req.func;
                seen.reg_offset = req.reg_offset;
                seen.write_data = req.write_data;
                seen.lines_low = req.lines_low;
                seen.lines_high = req.lines_high;
                expected_rsp_q.push_back(apply_request(seen));
            end
            outstanding <= expected_rsp_q.size();
        end
    end

endmodule

@@ test/tb_two_bank_interrupt_controller_core.sv @@
`timescale 1ns / 1ps
// Testbench top for two_bank_interrupt_controller_core: clock, reset, request
// traffic and response back-pressure; the verdict comes from tbic_checker.
// Depends on tbic_pkg, tbic_if.sv, tbic_checker.sv and the core itself.

module tb_two_bank_interrupt_controller_core;
    import tbic_pkg::*;

    localparam logic [1:0] FUNC_NOP = 2'd3;

    // Offsets outside the register map
    localparam logic [4:0] OFS_HIGH_SPARE = 5'h0C;
    localparam logic [4:0] OFS_LOW_SPARE  = 5'h1C;
    localparam logic [4:0] OFS_MISALIGNED = 5'h15;
    localparam logic [4:0] OFS_LAST       = 5'h1F;

    localparam int RandomRequests = 400;

    logic clk;
    logic rst_n;
    logic no_idle;
    int   mismatches;
    int   responses_seen;
    int   outstanding;
    int   tick_count;
    int   read_count;
    int   write_count;
    int   nop_count;

    logic [4:0] mapped_offsets [6] = '{OFS_HIGH_EVENTS, OFS_HIGH_ENABLES, OFS_HIGH_CLEAR,
                                       OFS_LOW_EVENTS, OFS_LOW_ENABLES, OFS_LOW_CLEAR};

    tbic_req_if req_bus ();
    tbic_rsp_if rsp_bus ();

    two_bank_interrupt_controller_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    tbic_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_bus),
        .rsp            (rsp_bus),
        .mismatches     (mismatches),
        .responses_seen (responses_seen),
        .outstanding    (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mix of empty, single-line, sparse, dense and full words
    function automatic logic [WordWidth-1:0] line_pattern();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 32'h1 << $urandom_range(0, 31);
            2:       return $urandom & $urandom & $urandom;
            3:       return $urandom & $urandom;
            4:       return $urandom;
            default: return '1;
        endcase
    endfunction

    task automatic issue_request(input logic [1:0] f, input logic [4:0] ofs,
                                 input logic [WordWidth-1:0] wdata,
                                 input logic [WordWidth-1:0] lo,
                                 input logic [WordWidth-1:0] hi);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.func       <= f;
        req_bus.reg_offset <= ofs;
        req_bus.write_data <= wdata;
        req_bus.lines_low  <= lo;
        req_bus.lines_high <= hi;
        do @(posedge clk); while (req_bus.ready !== 1'b1);
        case (f)
            FUNC_TICK:  tick_count++;
            FUNC_READ:  read_count++;
            FUNC_WRITE: write_count++;
            default:    nop_count++;
        endcase
    endtask

    task automatic random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 34)
            issue_request(FUNC_TICK, 5'($urandom), $urandom, line_pattern(), line_pattern());
        else if (pick < 50)
            issue_request(FUNC_WRITE,
                          ($urandom_range(0, 1) != 0) ? OFS_LOW_ENABLES : OFS_HIGH_ENABLES,
                          line_pattern(), $urandom, $urandom);
        else if (pick < 64)
            issue_request(FUNC_WRITE,
                          ($urandom_range(0, 1) != 0) ? OFS_LOW_CLEAR : OFS_HIGH_CLEAR,
                          line_pattern(), $urandom, $urandom);
        else if (pick < 84)
            issue_request(FUNC_READ, mapped_offsets[$urandom_range(0, 5)],
                          $urandom, $urandom, $urandom);
        else if (pick < 94)
            issue_request(($urandom_range(0, 1) != 0) ? FUNC_READ : FUNC_WRITE,
                          5'($urandom_range(0, 31)), $urandom, $urandom, $urandom);
        else
            issue_request(FUNC_NOP, 5'($urandom), $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        no_idle            <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.func       <= FUNC_TICK;
        req_bus.reg_offset <= OFS_HIGH_EVENTS;
        req_bus.write_data <= '0;
        req_bus.lines_low  <= '0;
        req_bus.lines_high <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset contents, then latch everything while all lines are masked
        issue_request(FUNC_READ, OFS_LOW_EVENTS, '1, '1, '1);
        issue_request(FUNC_READ, OFS_LOW_ENABLES, '0, '0, '0);
        issue_request(FUNC_READ, OFS_HIGH_EVENTS, '0, '0, '0);
        issue_request(FUNC_READ, OFS_HIGH_ENABLES, '0, '0, '0);
        issue_request(FUNC_TICK, OFS_LAST, '1, '1, '1);
        // Top lines of each bank, low bank taking priority
        issue_request(FUNC_WRITE, OFS_HIGH_ENABLES, 32'h8000_0000, '0, '0);
        issue_request(FUNC_WRITE, OFS_LOW_ENABLES, 32'h8000_0000, '1, '1);
        issue_request(FUNC_READ, OFS_LOW_EVENTS, '1, '0, '0);
        issue_request(FUNC_READ, OFS_LOW_CLEAR, '0, '0, '0);
        issue_request(FUNC_READ, OFS_HIGH_CLEAR, '0, '0, '0);
        // Event registers are read only
        issue_request(FUNC_WRITE, OFS_LOW_EVENTS, '0, '0, '0);
        issue_request(FUNC_WRITE, OFS_HIGH_EVENTS, '0, '0, '0);
        // Clear the low bank: the high bank takes over until lines relatch
        issue_request(FUNC_WRITE, OFS_LOW_CLEAR, '1, '0, '0);
        issue_request(FUNC_TICK, OFS_HIGH_EVENTS, '1, '0, '0);
        issue_request(FUNC_WRITE, OFS_HIGH_CLEAR, 32'h7FFF_FFFF, '1, '1);
        issue_request(FUNC_WRITE, OFS_LOW_ENABLES, '1, '0, '0);
        issue_request(FUNC_TICK, OFS_HIGH_EVENTS, '0, 32'h0000_0001, '0);
        // Unused and misaligned offsets
        issue_request(FUNC_WRITE, OFS_HIGH_SPARE, '1, '0, '0);
        issue_request(FUNC_READ, OFS_HIGH_SPARE, '0, '0, '0);
        issue_request(FUNC_WRITE, OFS_MISALIGNED, '0, '0, '0);
        issue_request(FUNC_READ, OFS_MISALIGNED, '0, '0, '0);
        issue_request(FUNC_WRITE, OFS_LOW_SPARE, '0, '0, '0);
        issue_request(FUNC_READ, OFS_LAST, '0, '0, '0);
        issue_request(FUNC_NOP, OFS_LOW_CLEAR, '1, '1, '1);
        issue_request(FUNC_WRITE, OFS_LOW_CLEAR, 32'h0000_0001, '0, '0);
        issue_request(FUNC_WRITE, OFS_HIGH_CLEAR, '1, '0, '0);
        issue_request(FUNC_READ, OFS_HIGH_ENABLES, '0, '0, '0);

        for (int n = 0; n < RandomRequests; n++)
        begin
            // Switch idling off for a stretch now and then
            if (n % 40 == 0)
                no_idle <= ($urandom_range(0, 3) == 0);
            random_request();
        end
        req_bus.valid <= 1'b0;

        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);

        $display("Covered %0d requests: %0d ticks, %0d reads, %0d writes, %0d no-ops.",
                 tick_count + read_count + write_count + nop_count,
                 tick_count, read_count, write_count, nop_count);
        $display("Compared %0d responses against the predicted register state.",
                 responses_seen);
        if (mismatches == 0)
            $display("two_bank_interrupt_controller_core verification clean");
        else
            $display("two_bank_interrupt_controller_core verification failed");
        $finish;
    end

    // Response side: hold ready low for a random stall before each transaction
    initial
    begin
        int stall;
        rsp_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge clk); while (rsp_bus.valid !== 1'b1);
        end
    end

    initial
    begin
        #2_000_000;
        $display("two_bank_interrupt_controller_core verification failed");
        $finish;
    end

endmodule
